[rtl/vp8bq_pkg.sv]
// Shared types, widths and the zigzag scan table for the 4x4 block quantizer.
`default_nettype none
package vp8bq_pkg;

    localparam int BLOCK_SIZE = 16;
    localparam int IDX_W      = 4;
    localparam int COEF_W     = 16;
    localparam int BIAS_W     = 32;
    localparam int PROD_W     = 32;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 32;

    localparam logic [IDX_W-1:0] LAST_IDX = 4'hf;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_FLUSH,
        ST_DRAIN
    } t_state;

    // Raster position of the coefficient at each zigzag position.
    function automatic logic [IDX_W-1:0] scan_pos(input logic [IDX_W-1:0] k);
        logic [IDX_W-1:0] p;
        unique case (k)
            4'd0:    p = 4'd0;
            4'd1:    p = 4'd1;
            4'd2:    p = 4'd4;
            4'd3:    p = 4'd8;
            4'd4:    p = 4'd5;
            4'd5:    p = 4'd2;
            4'd6:    p = 4'd3;
            4'd7:    p = 4'd6;
            4'd8:    p = 4'd9;
            4'd9:    p = 4'd12;
            4'd10:   p = 4'd13;
            4'd11:   p = 4'd10;
            4'd12:   p = 4'd7;
            4'd13:   p = 4'd11;
            4'd14:   p = 4'd14;
            default: p = 4'd15;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

[rtl/vp8bq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module vp8bq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_wr_en,
    input  wire  [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire  [WIDTH-1:0]         i_wr_data,
    input  wire                      i_rd_en,
    input  wire  [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

[rtl/vp8_block_quantizer_core.sv]
// VP8 4x4 block quantizer: per-coefficient quantize, store, zigzag drain.
//
// Input channel (s_axis): one coefficient of a 4x4 block per item in raster
// order, with its step, inverse step, rounding bias and sharpening bias.
// Output channel (m_axis): 16 items per block, each with the level at zigzag
// position k, the dequantized value at raster position k, the block nonzero
// flag in tuser, and tlast on the sixteenth.
// Items enter one per cycle through a four-stage arithmetic pipeline that
// writes level and dequantized value into two 16-entry RAMs. After the 16th
// coefficient the input closes until the whole block has been drained.
// The drain begins once the 16th coefficient reaches the RAM write stage.
// Each result's RAM read is issued only once the previous read has landed
// and the output register is free, so reads never overlap. The input
// reopens once the last item of the block has been taken.
// A stalled receiver holds the output register; no read is issued until it
// frees. Synchronous reset returns to the fill state at raster position 0;
// RAM contents are not cleared and are always written before they are read.
`default_nettype none
module vp8_block_quantizer_core #(
    parameter int LEVEL_LIMIT = 2047,
    parameter int QUANT_SHIFT = 17
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // coefficient[15:0], step[31:16], inverse_step[47:32],
    // rounding_bias[79:48], sharp_bias[95:80]
    input  wire  [vp8bq_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // zigzag_level[15:0], dequantized[31:16]
    output logic [vp8bq_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // block_nonzero[0]
    output logic                               m_axis_tuser,
    output logic                               m_axis_tlast
);
    import vp8bq_pkg::*;

    localparam logic signed [PROD_W-1:0] LIM_HI = PROD_W'(LEVEL_LIMIT);
    localparam logic signed [PROD_W-1:0] LIM_LO = -PROD_W'(32768);

    t_state r_state, n_state;

    logic [IDX_W-1:0] r_in_pos;
    logic             in_accept, out_accept;

    // Stage 1: registered input item
    logic                    r_s1_vld;
    logic [COEF_W-1:0]       r_s1_coef, r_s1_step, r_s1_iq, r_s1_sharp;
    logic [BIAS_W-1:0]       r_s1_bias;
    logic [IDX_W-1:0]        r_s1_pos;
    // Stage 2: product
    logic                    r_s2_vld, r_s2_neg;
    logic [PROD_W-1:0]       r_s2_prod;
    logic [BIAS_W-1:0]       r_s2_bias;
    logic [COEF_W-1:0]       r_s2_step;
    logic [IDX_W-1:0]        r_s2_pos;
    // Stage 3: level
    logic                    r_s3_vld;
    logic [COEF_W-1:0]       r_s3_level, r_s3_step;
    logic [IDX_W-1:0]        r_s3_pos;
    // Stage 4: RAM write
    logic                    r_s4_vld;
    logic [COEF_W-1:0]       r_s4_level, r_s4_dq;
    logic [IDX_W-1:0]        r_s4_pos;

    logic                    r_any, r_blk_nz;
    logic [IDX_W-1:0]        r_rd_idx;
    logic                    r_rd_done, r_inflight, r_inflight_last;
    logic                    rd_issue;

    logic                    s1_neg;
    logic [COEF_W-1:0]       s1_mag;
    logic [PROD_W-1:0]       s2_sum;
    logic signed [PROD_W-1:0] s2_shifted;
    logic [COEF_W-1:0]       s2_q, s2_level;
    logic [PROD_W-1:0]       s3_prod;
    logic [COEF_W-1:0]       lvl_rd, dq_rd;
    logic                    fill_done;

    assign s_axis_tready = (r_state == ST_FILL);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_accept    = m_axis_tvalid && m_axis_tready;
    assign fill_done     = r_s4_vld && (r_s4_pos == LAST_IDX);
    assign rd_issue      = (r_state == ST_DRAIN) && !r_rd_done && !r_inflight
                           && (!m_axis_tvalid || m_axis_tready);

    // Datapath arithmetic
    always_comb begin
        s1_neg = r_s1_coef[COEF_W-1];
        s1_mag = (s1_neg ? (~r_s1_coef + 16'd1) : r_s1_coef) + r_s1_sharp;

        s2_sum     = r_s2_prod + r_s2_bias;
        s2_shifted = $signed(s2_sum) >>> QUANT_SHIFT;
        priority if (s2_shifted > LIM_HI) begin
            s2_q = LIM_HI[COEF_W-1:0];
        end else if (s2_shifted < LIM_LO) begin
            s2_q = LIM_LO[COEF_W-1:0];
        end else begin
            s2_q = s2_shifted[COEF_W-1:0];
        end
        s2_level = r_s2_neg ? (~s2_q + 16'd1) : s2_q;

        s3_prod = r_s3_level * r_s3_step;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_FILL: begin
                if (in_accept && (r_in_pos == LAST_IDX)) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (fill_done) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_accept && m_axis_tlast) begin
                    n_state = ST_FILL;
                end
            end
            default: n_state = ST_FILL;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_FILL;
            r_in_pos      <= '0;
            r_s1_vld      <= 1'b0;
            r_s2_vld      <= 1'b0;
            r_s3_vld      <= 1'b0;
            r_s4_vld      <= 1'b0;
            r_any         <= 1'b0;
            r_rd_idx      <= '0;
            r_rd_done     <= 1'b0;
            r_inflight    <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_s1_vld <= in_accept;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            if (in_accept) begin
                r_in_pos <= r_in_pos + 4'd1;
            end
            // Clear the nonzero flag as the block moves to draining
            if (r_state == ST_FLUSH && fill_done) begin
                r_any <= 1'b0;
            end else if (r_s4_vld && (r_s4_level != '0)) begin
                r_any <= 1'b1;
            end
            if (r_state != ST_DRAIN) begin
                r_rd_idx  <= '0;
                r_rd_done <= 1'b0;
            end else if (rd_issue) begin
                r_rd_idx <= r_rd_idx + 4'd1;
                if (r_rd_idx == LAST_IDX) begin
                    r_rd_done <= 1'b1;
                end
            end
            r_inflight <= rd_issue;
            if (r_inflight) begin
                m_axis_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_coef  <= s_axis_tdata[15:0];
            r_s1_step  <= s_axis_tdata[31:16];
            r_s1_iq    <= s_axis_tdata[47:32];
            r_s1_bias  <= s_axis_tdata[79:48];
            r_s1_sharp <= s_axis_tdata[95:80];
            r_s1_pos   <= r_in_pos;
        end
        r_s2_prod  <= s1_mag * r_s1_iq;
        r_s2_bias  <= r_s1_bias;
        r_s2_neg   <= s1_neg;
        r_s2_step  <= r_s1_step;
        r_s2_pos   <= r_s1_pos;
        r_s3_level <= s2_level;
        r_s3_step  <= r_s2_step;
        r_s3_pos   <= r_s2_pos;
        r_s4_level <= r_s3_level;
        r_s4_dq    <= s3_prod[COEF_W-1:0];
        r_s4_pos   <= r_s3_pos;
        if (r_state == ST_FLUSH && fill_done) begin
            r_blk_nz <= r_any || (r_s4_level != '0);
        end
        if (rd_issue) begin
            r_inflight_last <= (r_rd_idx == LAST_IDX);
        end
        if (r_inflight) begin
            m_axis_tdata <= {dq_rd, lvl_rd};
            m_axis_tuser <= r_blk_nz;
            m_axis_tlast <= r_inflight_last;
        end
    end

    vp8bq_ram #(
        .WIDTH(16),
        .DEPTH(16)
    ) u_level_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_s4_vld),
        .i_wr_addr (r_s4_pos),
        .i_wr_data (r_s4_level),
        .i_rd_en   (rd_issue),
        .i_rd_addr (scan_pos(r_rd_idx)),
        .o_rd_data (lvl_rd)
    );

    vp8bq_ram #(
        .WIDTH(16),
        .DEPTH(16)
    ) u_dequant_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_s4_vld),
        .i_wr_addr (r_s4_pos),
        .i_wr_data (r_s4_dq),
        .i_rd_en   (rd_issue),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (dq_rd)
    );

`ifndef SYNTH
    a_no_out_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL) |-> !m_axis_tvalid)
        else $error("result item shown while filling");
    a_read_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight |-> (r_state == ST_DRAIN))
        else $error("RAM read outside drain");
    a_no_write_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_vld |-> (r_state != ST_DRAIN))
        else $error("RAM write overlaps drain");
    a_last_ends_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_accept && m_axis_tlast) |=> (r_state == ST_FILL) && (r_in_pos == '0))
        else $error("block did not close after last item");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inflight && m_axis_tvalid) |-> $past(m_axis_tready))
        else $error("read data would overwrite a held item");
`endif

endmodule
`default_nettype wire

[dv/quant_block_checker.sv]
// Watches both streams of the block quantizer, predicts each result and compares it.
`timescale 1ns / 100ps
module quant_block_checker #(
    parameter int LEVEL_LIMIT = 2047,
    parameter int QUANT_SHIFT = 17
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_coef_valid,
    input  wire                                i_coef_ready,
    input  wire  [vp8bq_pkg::IN_DATA_W-1:0]    i_coef_data,
    input  wire                                i_res_valid,
    input  wire                                i_res_ready,
    input  wire  [vp8bq_pkg::OUT_DATA_W-1:0]   i_res_data,
    input  wire                                i_res_nonzero,
    input  wire                                i_res_last,
    output int                                 o_pending,
    output int                                 o_errors,
    output int                                 o_checked,
    output int                                 o_zero_blocks
);
    import vp8bq_pkg::*;

    typedef struct packed {
        logic [15:0] level;
        logic [15:0] dequant;
        logic        nonzero;
        logic        last;
    } t_block_result;

    // raster position for each zigzag slot, slot 0 in the lowest nibble
    localparam logic [63:0] ZIGZAG_POS = {
        4'd15, 4'd14, 4'd11, 4'd7, 4'd10, 4'd13, 4'd12, 4'd9,
        4'd6,  4'd3,  4'd2,  4'd5, 4'd8,  4'd4,  4'd1,  4'd0
    };
    localparam int REPORT_LIMIT = 10;

    t_block_result zigzag_queue[$];
    logic [15:0]   level_mem   [BLOCK_SIZE];
    logic [15:0]   dequant_mem [BLOCK_SIZE];
    logic [3:0]    raster_pos;
    logic          block_nz;
    int            fails;
    int            checked;
    int            zero_blocks;

    function automatic logic [15:0] quantize_coef(input logic [15:0] coef,
                                                  input logic [15:0] inv_step,
                                                  input logic [31:0] round_bias,
                                                  input logic [15:0] sharpen);
        logic [15:0]        mag;
        logic [31:0]        acc;
        logic signed [31:0] shifted;
        logic [15:0]        level;
        mag = coef[15] ? 16'(~coef + 16'd1) : coef;
        mag = mag + sharpen;
        acc = mag * inv_step + round_bias;
        shifted = $signed(acc) >>> QUANT_SHIFT;
        if (shifted > LEVEL_LIMIT) begin
            shifted = LEVEL_LIMIT;
        end else if (shifted < -32768) begin
            shifted = -32768;
        end
        level = shifted[15:0];
        if (coef[15]) begin
            level = 16'(~level + 16'd1);
        end
        return level;
    endfunction

    always @(posedge i_clk) begin
        t_block_result want;
        logic [15:0]   got_level;
        logic [15:0]   got_dequant;
        logic [15:0]   lvl;
        int            k;
        if (!i_rst_n) begin
            zigzag_queue.delete();
            raster_pos  = '0;
            block_nz    = 1'b0;
            fails       = 0;
            checked     = 0;
            zero_blocks = 0;
        end else begin
            if (i_res_valid && i_res_ready) begin
                got_level   = i_res_data[15:0];
                got_dequant = i_res_data[31:16];
                if (zigzag_queue.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_LIMIT) begin
                        $display("%0t: result with nothing expected: level %0d dequant %0d",
                                 $realtime, $signed(got_level), $signed(got_dequant));
                    end
                end else begin
                    want = zigzag_queue.pop_front();
                    if (got_level !== want.level || got_dequant !== want.dequant ||
                        i_res_nonzero !== want.nonzero || i_res_last !== want.last) begin
                        fails++;
                        if (fails <= REPORT_LIMIT) begin
                            $display("%0t: result %0d mismatch: level exp %0d got %0d, %s",
                                     $realtime, checked, $signed(want.level),
                                     $signed(got_level), "see next line");
                            $display("    dequant exp %0d got %0d, nonzero exp %b got %b,",
                                     $signed(want.dequant), $signed(got_dequant),
                                     want.nonzero, i_res_nonzero);
                            $display("    last exp %b got %b", want.last, i_res_last);
                        end
                    end
                    checked++;
                end
            end
            if (i_coef_valid && i_coef_ready) begin
                lvl = quantize_coef(i_coef_data[15:0], i_coef_data[47:32],
                                    i_coef_data[79:48], i_coef_data[95:80]);
                level_mem[raster_pos]   = lvl;
                dequant_mem[raster_pos] = lvl * i_coef_data[31:16];
                if (lvl != 16'd0) begin
                    block_nz = 1'b1;
                end
                // the sixteenth item releases the whole block
                if (raster_pos == LAST_IDX) begin
                    for (k = 0; k < BLOCK_SIZE; k++) begin
                        want.level   = level_mem[ZIGZAG_POS[4*k +: 4]];
                        want.dequant = dequant_mem[k];
                        want.nonzero = block_nz;
                        want.last    = (k == BLOCK_SIZE - 1);
                        zigzag_queue.push_back(want);
                    end
                    if (!block_nz) begin
                        zero_blocks++;
                    end
                    block_nz = 1'b0;
                end
                raster_pos = raster_pos + 4'd1;
            end
        end
        o_pending     <= zigzag_queue.size();
        o_errors      <= fails;
        o_checked     <= checked;
        o_zero_blocks <= zero_blocks;
    end

endmodule

[dv/testbench.sv]
// Stimulus and verdict for the 4x4 block quantizer: directed and random blocks.
`timescale 1ns / 100ps
module testbench;
    import vp8bq_pkg::*;

    typedef enum int {
        BLK_TYPICAL,
        BLK_WILD,
        BLK_QUIET,
        BLK_EDGY
    } t_block_kind;

    localparam int RANDOM_BLOCKS = 12;
    localparam int TAIL_BLOCK    = 8;
    localparam int PAUSE_BLOCK   = 6;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  coef_valid  = 1'b0;
    logic                  coef_ready;
    logic [IN_DATA_W-1:0]  coef_data   = '0;
    logic                  res_valid;
    logic                  res_ready   = 1'b0;
    logic [OUT_DATA_W-1:0] res_data;
    logic                  res_nonzero;
    logic                  res_last;
    logic                  rx_stalls   = 1'b0;
    logic                  tx_gaps     = 1'b0;
    int                    stall_left  = 0;
    int                    pending;
    int                    errors;
    int                    checked;
    int                    zero_blocks;

    always #6 i_clk = ~i_clk;

    vp8_block_quantizer_core #(
        .LEVEL_LIMIT(2047),
        .QUANT_SHIFT(17)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (coef_valid),
        .s_axis_tready (coef_ready),
        .s_axis_tdata  (coef_data),
        .m_axis_tvalid (res_valid),
        .m_axis_tready (res_ready),
        .m_axis_tdata  (res_data),
        .m_axis_tuser  (res_nonzero),
        .m_axis_tlast  (res_last)
    );

    quant_block_checker #(
        .LEVEL_LIMIT(2047),
        .QUANT_SHIFT(17)
    ) checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_coef_valid  (coef_valid),
        .i_coef_ready  (coef_ready),
        .i_coef_data   (coef_data),
        .i_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .i_res_data    (res_data),
        .i_res_nonzero (res_nonzero),
        .i_res_last    (res_last),
        .o_pending     (pending),
        .o_errors      (errors),
        .o_checked     (checked),
        .o_zero_blocks (zero_blocks)
    );

    // receiver: ready, with random stall bursts while stalls are enabled
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            res_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (rx_stalls && $urandom_range(0, 4) == 0) begin
            res_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 8);
        end else begin
            res_ready <= 1'b1;
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_coef(input logic [15:0] coef,
                                                        input logic [15:0] step,
                                                        input logic [15:0] inv_step,
                                                        input logic [31:0] bias,
                                                        input logic [15:0] sharpen);
        return {sharpen, bias, inv_step, step, coef};
    endfunction

    function automatic logic [15:0] edgy16();
        logic [15:0] v;
        case ($urandom_range(0, 5))
            0:       v = 16'h0000;
            1:       v = 16'h0001;
            2:       v = 16'h7FFF;
            3:       v = 16'h8000;
            4:       v = 16'hFFFF;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    // extremes, sign edges and wrap cases in one block
    function automatic logic [IN_DATA_W-1:0] directed_coef(input int idx);
        logic [IN_DATA_W-1:0] w;
        case (idx)
            0:  w = pack_coef(16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 16'h0000);
            1:  w = pack_coef(16'h7FFF, 16'hFFFF, 16'hFFFF, 32'h0000_0000, 16'h0000);
            2:  w = pack_coef(16'h8000, 16'hFFFF, 16'hFFFF, 32'h0000_0000, 16'h0000);
            3:  w = pack_coef(16'h8000, 16'h0001, 16'h0001, 32'h0000_0000, 16'h0000);
            4:  w = pack_coef(16'h7FFF, 16'd100,  16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
            5:  w = pack_coef(16'h0001, 16'd7,    16'h0001, 32'h8000_0000, 16'h0000);
            6:  w = pack_coef(16'hFFFF, 16'd3,    16'hFFFF, 32'hFFFF_FFFF, 16'h0000);
            7:  w = pack_coef(16'h8000, 16'h8000, 16'hFFFF, 32'h8000_0000, 16'hFFFF);
            8:  w = pack_coef(16'd100,  16'd16,   16'd8192, 32'h0000_B000, 16'd12);
            9:  w = pack_coef(-16'sd100, 16'd16,  16'd8192, 32'h0000_B000, 16'h0000);
            10: w = pack_coef(16'h0000, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 16'hFFFF);
            11: w = pack_coef(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 16'h0000);
            12: w = pack_coef(16'h5555, 16'hAAAA, 16'h5555, 32'hAAAA_AAAA, 16'h5555);
            13: w = pack_coef(16'hAAAA, 16'h5555, 16'hAAAA, 32'h5555_5555, 16'hAAAA);
            14: w = pack_coef(16'd2047, 16'h0001, 16'h0400, 32'h0000_0000, 16'h0000);
            default: w = pack_coef(-16'sd2048, 16'd2, 16'hFFFF, 32'h0000_0000, 16'h0000);
        endcase
        return w;
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_coef(input t_block_kind kind);
        logic [15:0] coef;
        logic [15:0] step;
        logic [15:0] inv_step;
        logic [31:0] bias;
        logic [15:0] sharpen;
        int          mag;
        case (kind)
            BLK_TYPICAL: begin
                step     = 16'($urandom_range(3, 1200));
                inv_step = 16'(131072 / step);
                bias     = $urandom_range(0, (1 << 17) - 1);
                sharpen  = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(0, 64));
                mag      = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767)
                                                       : $urandom_range(0, 4 * step);
                coef     = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
            end
            BLK_QUIET: begin
                mag      = $urandom_range(0, 3);
                coef     = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
                step     = 16'($urandom);
                inv_step = 16'($urandom_range(0, 1000));
                bias     = $urandom_range(0, 1000);
                sharpen  = 16'd0;
            end
            BLK_EDGY: begin
                coef     = edgy16();
                step     = edgy16();
                inv_step = edgy16();
                sharpen  = edgy16();
                case ($urandom_range(0, 4))
                    0:       bias = 32'h0000_0000;
                    1:       bias = 32'h7FFF_FFFF;
                    2:       bias = 32'h8000_0000;
                    3:       bias = 32'hFFFF_FFFF;
                    default: bias = $urandom;
                endcase
            end
            default: begin
                coef     = 16'($urandom);
                step     = 16'($urandom);
                inv_step = 16'($urandom);
                bias     = $urandom;
                sharpen  = 16'($urandom);
            end
        endcase
        return pack_coef(coef, step, inv_step, bias, sharpen);
    endfunction

    task automatic send_coef(input logic [IN_DATA_W-1:0] word);
        int gap;
        gap = 0;
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
        end
        if (gap != 0) begin
            coef_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        coef_data  <= word;
        coef_valid <= 1'b1;
        do @(posedge i_clk); while (!coef_ready);
    endtask

    // hold the sender until every released result has been checked
    task automatic wait_drained();
        coef_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int          b;
        int          i;
        int          items;
        t_block_kind kind;
        items = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n   <= 1'b1;
        rx_stalls <= 1'b1;
        tx_gaps = 1'b1;
        @(posedge i_clk);

        for (i = 0; i < BLOCK_SIZE; i++) begin
            send_coef(directed_coef(i));
            items++;
        end

        for (b = 0; b < RANDOM_BLOCKS; b++) begin
            kind = (b < 4) ? t_block_kind'(b) : t_block_kind'($urandom_range(0, 3));
            tx_gaps = !(b == 2 || b >= TAIL_BLOCK);
            rx_stalls <= !(b == 2 || b >= TAIL_BLOCK);
            for (i = 0; i < BLOCK_SIZE; i++) begin
                send_coef(random_coef(kind));
                items++;
            end
            if (b == PAUSE_BLOCK) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        $display("sent %0d coefficients in %0d blocks, checked %0d zigzag results",
                 items, items / BLOCK_SIZE, checked);
        $display("blocks predicted with all-zero levels: %0d", zero_blocks);
        if (errors == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial begin
        #2_400_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/vp8bq_pkg.sv
rtl/vp8bq_ram.sv
rtl/vp8_block_quantizer_core.sv
dv/quant_block_checker.sv
dv/testbench.sv
